>>> rtl/rcws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcws_pkg: shared types and constants of the RC4 word scrambler
// Sizes, register indexes, controller states, and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rcws_pkg;

    localparam int WORD_W        = 64;
    localparam int BYTE_W        = 8;
    localparam int WORD_BYTES    = WORD_W / BYTE_W;
    localparam int PERM_DEPTH    = 256;
    localparam int PERM_AW       = $clog2(PERM_DEPTH);
    localparam int KEY_BYTES_DEF = 16;
    localparam int KEY_BYTES_MAX = 16;
    localparam int KEY_IDX_W     = $clog2(KEY_BYTES_MAX);
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_GN_RD_I,
        ST_GN_RD_J,
        ST_GN_WR_I,
        ST_GN_WR_J,
        ST_GN_RD_C,
        ST_GN_CAP,
        ST_EMIT
    } state_t;

    // Address source for the permutation memory
    typedef enum logic [2:0] {
        ADDR_CNT,
        ADDR_ACC_NEXT,
        ADDR_ACC,
        ADDR_ONE,
        ADDR_RDATA,
        ADDR_SI,
        ADDR_SUM
    } addr_sel_t;

    // Write data source for the permutation memory
    typedef enum logic [1:0] {
        WDATA_CNT,
        WDATA_RDATA,
        WDATA_SI
    } wdata_sel_t;

    typedef struct packed {
        logic       word_load;
        logic       out_load;
        logic       out_held;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       ks_init;
        logic       ksa_step;
        logic       key_adv;
        logic       a1_load;
        logic       sj_load;
        logic       c_load;
        logic       ram_re;
        logic       ram_we;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic stream_valid;
    } sts_t;

    // Reverse the byte order of a word and XOR every byte with c
    function automatic logic [WORD_W-1:0] swap_xor(input logic [WORD_W-1:0] w,
                                                   input logic [BYTE_W-1:0] c);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < WORD_BYTES; k++) begin
            r[(WORD_BYTES-1-k)*BYTE_W +: BYTE_W] = w[k*BYTE_W +: BYTE_W] ^ c;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/rc4_word_scrambler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_word_scrambler: keyed byte-reversing XOR scrambler for 64-bit words
//
// Usage:
//   Configuration: write key_low (index 0) and key_high (index 1) over the
//   cfg channel; cfg_ready is always high. Write only while busy is low.
//   Any key write marks the keystream byte stale.
//   Requests: drive word_in and raise start; the request is taken at a clock
//   edge where start is high and busy is low.
//   Results: word_out is valid for exactly one cycle while done is high;
//   the receiver must take it then, it cannot stall the block.
//   Timing: with a current keystream byte, done rises the cycle after the
//   request and a new request may be taken every cycle (one word per cycle).
//   The first request after reset or a key write runs the RC4 key schedule
//   on the 256-entry permutation memory: a fill of all 256 entries, then
//   one mix step per entry (one memory read port, two reads and two writes
//   per step), then the first generation step and output. busy stays high
//   meanwhile.
//   Reset: keys clear to zero, the keystream byte is stale, no result is
//   pending. The permutation memory needs no clearing, the schedule
//   rewrites all of it before any read.
// ----------------------------------------------------------------------------
module rc4_word_scrambler #(
    parameter int KEY_BYTES = rcws_pkg::KEY_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request channel
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [rcws_pkg::WORD_W-1:0]      word_in,
    // result channel
    output logic                                  done,
    output logic      [rcws_pkg::WORD_W-1:0]      word_out,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rcws_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rcws_pkg::WORD_W-1:0]      cfg_data
);
    import rcws_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic cfg_we;

    // Writes must arrive only while idle; the block does not enforce this and ties cfg_ready high
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    rcws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    rcws_dp #(
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .word_in   (word_in),
        .cmd       (cmd),
        .sts       (sts),
        .word_out  (word_out),
        .done      (done)
    );

    // Fast path: a request with a current keystream byte answers next cycle
    a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && sts.stream_valid) |=> (done && !busy))
        else $error("request with current key byte gave no result next cycle");

    // Slow path: a stale keystream byte starts the schedule
    a_schedule_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !sts.stream_valid) |=> (busy && !done))
        else $error("stale key byte did not start the schedule");

    // Hold the permutation memory untouched while idle
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_we |-> busy)
        else $error("permutation write while idle");

endmodule
`default_nettype wire

>>> rtl/rcws_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcws_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rcws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/rcws_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcws_ctrl: sequencing of the key schedule and word requests
// Steps the datapath through fill, key mixing, the first generation step and the output load.
// ----------------------------------------------------------------------------
module rcws_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire rcws_pkg::sts_t sts,
    output rcws_pkg::cmd_t     cmd,
    output logic               busy
);
    import rcws_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !sts.stream_valid)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:    if (sts.cnt_last) state_next = ST_KS_RD_I;
            ST_KS_RD_I: state_next = ST_KS_RD_J;
            ST_KS_RD_J: state_next = ST_KS_WR_I;
            ST_KS_WR_I: state_next = ST_KS_WR_J;
            ST_KS_WR_J: state_next = sts.cnt_last ? ST_GN_RD_I : ST_KS_RD_I;
            ST_GN_RD_I: state_next = ST_GN_RD_J;
            ST_GN_RD_J: state_next = ST_GN_WR_I;
            ST_GN_WR_I: state_next = ST_GN_WR_J;
            ST_GN_WR_J: state_next = ST_GN_RD_C;
            ST_GN_RD_C: state_next = ST_GN_CAP;
            ST_GN_CAP:  state_next = ST_EMIT;
            ST_EMIT:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.addr_sel  = ADDR_CNT;
        cmd.wdata_sel = WDATA_CNT;
        busy          = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.out_load  = sts.stream_valid;
                    cmd.word_load = !sts.stream_valid;
                    cmd.cnt_clr   = !sts.stream_valid;
                end
            end
            ST_FILL:
            begin
                cmd.ram_we  = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.ks_init = 1'b1;
            end
            ST_KS_RD_I:
            begin
                cmd.ram_re = 1'b1;
            end
            ST_KS_RD_J:
            begin
                cmd.ksa_step = 1'b1;
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = ADDR_ACC_NEXT;
            end
            ST_KS_WR_I:
            begin
                cmd.ram_we    = 1'b1;
                cmd.wdata_sel = WDATA_RDATA;
            end
            ST_KS_WR_J:
            begin
                cmd.ram_we    = 1'b1;
                cmd.addr_sel  = ADDR_ACC;
                cmd.wdata_sel = WDATA_SI;
                cmd.cnt_inc   = 1'b1;
                cmd.key_adv   = 1'b1;
            end
            ST_GN_RD_I:
            begin
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = ADDR_ONE;
            end
            ST_GN_RD_J:
            begin
                cmd.a1_load  = 1'b1;
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = ADDR_RDATA;
            end
            ST_GN_WR_I:
            begin
                cmd.sj_load   = 1'b1;
                cmd.ram_we    = 1'b1;
                cmd.addr_sel  = ADDR_ONE;
                cmd.wdata_sel = WDATA_RDATA;
            end
            ST_GN_WR_J:
            begin
                cmd.ram_we    = 1'b1;
                cmd.addr_sel  = ADDR_SI;
                cmd.wdata_sel = WDATA_SI;
            end
            ST_GN_RD_C:
            begin
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = ADDR_SUM;
            end
            ST_GN_CAP:
            begin
                cmd.c_load = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.out_load = 1'b1;
                cmd.out_held = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/rcws_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcws_dp: datapath of the RC4 word scrambler
// Key registers, permutation memory, schedule registers and output stage.
// ----------------------------------------------------------------------------
module rcws_dp #(
    parameter int KEY_BYTES = rcws_pkg::KEY_BYTES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rcws_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rcws_pkg::WORD_W-1:0]        cfg_data,
    input  wire logic [rcws_pkg::WORD_W-1:0]        word_in,
    input  wire rcws_pkg::cmd_t                     cmd,
    output rcws_pkg::sts_t                          sts,
    output logic      [rcws_pkg::WORD_W-1:0]        word_out,
    output logic                                    done
);
    import rcws_pkg::*;

    // Key length in use, held to 1..16
    localparam int KEY_LEN = (KEY_BYTES < 1) ? 1 :
                             (KEY_BYTES > KEY_BYTES_MAX) ? KEY_BYTES_MAX : KEY_BYTES;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_LAST = KEY_IDX_W'(KEY_LEN - 1);
    localparam logic [PERM_AW-1:0]   CNT_LAST     = PERM_AW'(PERM_DEPTH - 1);
    localparam logic [PERM_AW-1:0]   ADDR_ONE_VAL = PERM_AW'(1);

    logic [WORD_W-1:0]    key_low_reg;
    logic [WORD_W-1:0]    key_high_reg;
    logic                 stream_valid_reg;
    logic [BYTE_W-1:0]    stream_byte_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [WORD_W-1:0]    word_out_reg;
    logic                 done_reg;
    logic [PERM_AW-1:0]   cnt_reg;
    logic [PERM_AW-1:0]   acc_reg;
    logic [KEY_IDX_W-1:0] kidx_reg;
    logic [BYTE_W-1:0]    si_reg;
    logic [BYTE_W-1:0]    sj_reg;

    logic [2*WORD_W-1:0]  key_all;
    logic [BYTE_W-1:0]    key_byte;
    logic [BYTE_W-1:0]    rdata;
    logic [PERM_AW-1:0]   acc_next;
    logic [PERM_AW-1:0]   addr;
    logic [BYTE_W-1:0]    wdata;

    assign key_all  = {key_high_reg, key_low_reg};
    assign key_byte = key_all[kidx_reg*BYTE_W +: BYTE_W];
    assign acc_next = acc_reg + rdata + key_byte;

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_CNT:      addr = cnt_reg;
            ADDR_ACC_NEXT: addr = acc_next;
            ADDR_ACC:      addr = acc_reg;
            ADDR_ONE:      addr = ADDR_ONE_VAL;
            ADDR_RDATA:    addr = rdata;
            ADDR_SI:       addr = si_reg;
            ADDR_SUM:      addr = si_reg + sj_reg;
            default:       addr = cnt_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wdata_sel)
            WDATA_CNT:   wdata = cnt_reg;
            WDATA_RDATA: wdata = rdata;
            WDATA_SI:    wdata = si_reg;
            default:     wdata = cnt_reg;
        endcase
    end

    rcws_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (addr),
        .wdata (wdata),
        .re    (cmd.ram_re),
        .raddr (addr),
        .rdata (rdata)
    );

    // Control state and key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg      <= '0;
            key_high_reg     <= '0;
            stream_valid_reg <= 1'b0;
            stream_byte_reg  <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.out_load;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    default:      key_low_reg  <= key_low_reg;
                endcase
                stream_valid_reg <= 1'b0;
            end
            else if (cmd.c_load)
            begin
                stream_valid_reg <= 1'b1;
            end
            if (cmd.c_load)
            begin
                stream_byte_reg <= rdata;
            end
        end
    end

    // Schedule registers and payload
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + PERM_AW'(1);
        end

        if (cmd.ks_init)
        begin
            acc_reg  <= '0;
            kidx_reg <= '0;
        end
        else
        begin
            if (cmd.ksa_step)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.key_adv)
            begin
                kidx_reg <= (kidx_reg == KEY_IDX_LAST) ? '0 : kidx_reg + KEY_IDX_W'(1);
            end
        end

        if (cmd.ksa_step || cmd.a1_load)
        begin
            si_reg <= rdata;
        end
        if (cmd.sj_load)
        begin
            sj_reg <= rdata;
        end
        if (cmd.word_load)
        begin
            word_reg <= word_in;
        end
        if (cmd.out_load)
        begin
            word_out_reg <= swap_xor(cmd.out_held ? word_reg : word_in, stream_byte_reg);
        end
    end

    assign sts.cnt_last     = (cnt_reg == CNT_LAST);
    assign sts.stream_valid = stream_valid_reg;
    assign word_out         = word_out_reg;
    assign done             = done_reg;

    // The schedule and the cached byte go together
    a_cfg_invalidates: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !stream_valid_reg)
        else $error("key write left the keystream byte marked current");

    a_cap_validates: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.c_load && !cfg_we) |=> (stream_valid_reg && stream_byte_reg == $past(rdata)))
        else $error("captured keystream byte not held");

    a_done_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.out_load))
        else $error("result strobe without an output load");

endmodule
`default_nettype wire
